[rtl/fawm_pkg.sv]
// fawm_pkg: shared types and constants for the flash access wear monitor.
// Used by fawm_seq and flash_access_wear_monitor; no dependencies.
package fawm_pkg;

  localparam logic [2:0] FuncRead   = 3'd0;
  localparam logic [2:0] FuncWrite  = 3'd1;
  localparam logic [2:0] FuncErase  = 3'd2;
  localparam logic [2:0] FuncBegin  = 3'd3;
  localparam logic [2:0] FuncEnd    = 3'd4;
  localparam logic [2:0] FuncReport = 3'd5;

  localparam logic [1:0] CfgValid  = 2'd0;
  localparam logic [1:0] CfgBase   = 2'd1;
  localparam logic [1:0] CfgLength = 2'd2;

  localparam int unsigned NumCounters = 6;

  typedef struct packed {
    logic [31:0] rd_calls;
    logic [31:0] rd_bytes;
    logic [31:0] wr_calls;
    logic [31:0] wr_bytes;
    logic [31:0] er_calls;
    logic [31:0] er_bytes;
    logic [5:0]  hot_sector;
    logic [31:0] hot_count;
    logic [6:0]  erased_sectors;
  } report_t;

endpackage

[rtl/fawm_seq.sv]
// fawm_seq: sequencer with counter and sector memories and one shared
// increment adder. Depends on fawm_pkg.
module fawm_seq #(
  parameter int unsigned Sectors     = 64,
  parameter int unsigned SectorBytes = 4096,
  parameter int unsigned Phases      = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  logic [2:0]          func_i,
  input  logic                hit_i,
  input  logic [31:0]         byte_offset_i,
  input  logic [31:0]         byte_count_i,
  input  logic [3:0]          phase_i,
  input  logic [3:0]          report_set_i,
  output logic                busy_o,
  output logic                done_o,
  output fawm_pkg::report_t   report_o
);

  localparam int unsigned Sets   = Phases + 2;
  localparam int unsigned SetW   = $clog2(Sets);
  localparam int unsigned SecW   = (Sectors > 1) ? $clog2(Sectors) : 1;
  localparam int unsigned SecCW  = $clog2(Sectors + 1);
  localparam int unsigned ShW    = $clog2(SectorBytes);
  localparam int unsigned CntDep = Sets * fawm_pkg::NumCounters;
  localparam int unsigned CntW   = $clog2(CntDep);
  localparam int unsigned SecDep = Sets * Sectors;
  localparam int unsigned SecAW  = $clog2(SecDep);
  localparam int unsigned EpW    = 8;

  localparam logic [3:0] StIdle = 4'd0, StCntRd = 4'd1, StCntWr = 4'd2,
                         StSecRd = 4'd3, StSecWr = 4'd4, StNext = 4'd5,
                         StClear = 4'd6, StRepCnt = 4'd7, StRepSec = 4'd8,
                         StDone = 4'd9, StCntLat = 4'd10, StSecLat = 4'd11,
                         StRepLat = 4'd12, StSecLat2 = 4'd13;

  // memories: words tagged with the epoch of the set at write time; a
  // mismatched epoch reads as zero, so begin run clears by bumping epochs
  logic [EpW+31:0] cnt_mem [CntDep];
  logic [EpW+31:0] sec_mem [SecDep];
  logic [EpW-1:0]  epoch_q [Sets];
  logic [EpW-1:0]  epoch_d [Sets];
  logic            epoch_wrap_q, epoch_wrap_d;

  logic [3:0]       st_q, st_d;
  logic [2:0]       func_q, func_d;
  logic [31:0]      count_q, count_d;
  logic [SetW-1:0]  set_q, set_d;
  logic [1:0]       pass_q, pass_d;
  logic [2:0]       ci_q, ci_d;
  logic [SecCW-1:0] sec_q, sec_d;
  logic [31:0]      first_q, first_d, last_q, last_d;
  logic             empty_q, empty_d;
  logic [3:0]       phase_q, phase_d;
  fawm_pkg::report_t rep_q, rep_d;

  logic            cnt_we, sec_we;
  logic [CntW-1:0] cnt_wa, cnt_ra;
  logic [SecAW-1:0] sec_wa, sec_ra;
  logic [EpW+31:0] cnt_wd, sec_wd, cnt_rd_q, sec_rd_q;
  logic [31:0]     cnt_val, sec_val, alu_a, alu_b, alu_sum;
  logic            sec_in_range;

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_q <= cnt_mem[cnt_ra];
    if (sec_we) sec_mem[sec_wa] <= sec_wd;
    sec_rd_q <= sec_mem[sec_ra];
  end

  // a sweep sets every tag to zero after reset so stale words read as zero
  assign cnt_val = (cnt_rd_q[EpW+31:32] == epoch_q[set_q]) ? cnt_rd_q[31:0] : '0;
  assign sec_val = (sec_rd_q[EpW+31:32] == epoch_q[set_q]) ? sec_rd_q[31:0] : '0;

  // shared adder
  assign alu_sum = alu_a + alu_b;

  always_comb begin
    cnt_ra = CntW'(set_q * fawm_pkg::NumCounters + ci_q);
    sec_ra = SecAW'(set_q * Sectors + sec_q[SecW-1:0]);
  end

  assign sec_in_range = (32'(sec_q) <= last_q) && (sec_q < SecCW'(Sectors));

  always_comb begin
    st_d = st_q; func_d = func_q; count_d = count_q; set_d = set_q;
    pass_d = pass_q; ci_d = ci_q; sec_d = sec_q; first_d = first_q;
    last_d = last_q; empty_d = empty_q; phase_d = phase_q;
    rep_d = rep_q; epoch_d = epoch_q; epoch_wrap_d = epoch_wrap_q;
    cnt_we = 1'b0; sec_we = 1'b0;
    cnt_wa = cnt_ra; sec_wa = sec_ra;
    cnt_wd = {epoch_q[set_q], alu_sum};
    sec_wd = {epoch_q[set_q], alu_sum};
    alu_a = '0; alu_b = '0;
    done_o = 1'b0;
    case (st_q)
      StClear: begin
        // tag sweep: both memories after reset; on an epoch wrap skip the campaign set
        cnt_we = (first_q < 32'(CntDep)) &&
                 !(epoch_wrap_q && first_q >= 32'(fawm_pkg::NumCounters) &&
                   first_q < 32'(2 * fawm_pkg::NumCounters));
        cnt_wa = CntW'(first_q);
        cnt_wd = '0;
        sec_we = (first_q < 32'(SecDep)) &&
                 !(epoch_wrap_q && first_q >= 32'(Sectors) && first_q < 32'(2 * Sectors));
        sec_wa = SecAW'(first_q);
        sec_wd = '0;
        first_d = first_q + 32'd1;
        if (first_q >= 32'(CntDep - 1) && first_q >= 32'(SecDep - 1)) begin
          st_d = StIdle;
          epoch_wrap_d = 1'b0;
        end
      end
      StIdle: begin
        if (go_i) begin
          func_d = func_i; count_d = byte_count_i; phase_d = phase_i;
          first_d = 32'(byte_offset_i >> ShW);
          last_d  = 32'((byte_offset_i + byte_count_i - 32'd1) >> ShW);
          empty_d = (byte_count_i == '0);
          pass_d = '0; set_d = '0;
          ci_d = 3'(func_i) << 1;
          case (func_i)
            fawm_pkg::FuncRead, fawm_pkg::FuncWrite, fawm_pkg::FuncErase:
              st_d = hit_i ? StCntLat : StDone;
            fawm_pkg::FuncBegin: begin
              st_d = StNext;
              pass_d = 2'd3;
            end
            fawm_pkg::FuncReport: begin
              rep_d = '0;
              if (32'(report_set_i) < 32'(Sets)) begin
                set_d = SetW'(report_set_i);
                ci_d = '0;
                st_d = StRepLat;
              end else st_d = StDone;
            end
            default: st_d = StDone;
          endcase
        end
      end
      StCntLat: st_d = StCntRd;
      StCntRd: begin
        // calls: +1, bytes: +count
        alu_a = cnt_val;
        alu_b = ci_q[0] ? count_q : 32'd1;
        cnt_we = 1'b1;
        if (!ci_q[0]) begin
          ci_d = ci_q + 3'd1;
          st_d = StCntLat;
        end else if (func_q == fawm_pkg::FuncErase && !empty_q &&
                     first_q <= last_q && first_q < 32'(Sectors)) begin
          sec_d = SecCW'(first_q);
          st_d = StSecLat;
        end else st_d = StNext;
      end
      StSecLat: st_d = StSecWr;
      StSecWr: begin
        alu_a = sec_val; alu_b = 32'd1;
        sec_we = 1'b1;
        sec_d = sec_q + SecCW'(1);
        st_d = StSecLat2;
      end
      StSecLat2: st_d = sec_in_range ? StSecWr : StNext;
      StNext: begin
        if (pass_q == 2'd3) begin
          // begin run: move run set and phase sets to fresh epochs
          for (int i = 0; i < Sets; i++)
            if (i != 1) epoch_d[i] = epoch_q[i] + EpW'(1);
          if (epoch_q[0] == {EpW{1'b1}}) begin
            // epochs wrap to zero: sweep run and phase entries so old words cannot match
            epoch_wrap_d = 1'b1;
            first_d = '0;
            st_d = StClear;
          end else st_d = StDone;
        end else if (pass_q == 2'd0) begin
          pass_d = 2'd1; set_d = SetW'(1); ci_d = 3'(func_q) << 1;
          st_d = StCntLat;
        end else if (pass_q == 2'd1 && 32'(phase_q) < 32'(Phases)) begin
          pass_d = 2'd2; set_d = SetW'(32'(phase_q) + 32'd2); ci_d = 3'(func_q) << 1;
          st_d = StCntLat;
        end else st_d = StDone;
      end
      StRepLat: st_d = StRepCnt;
      StRepCnt: begin
        case (ci_q)
          3'd0: rep_d.rd_calls = cnt_val;
          3'd1: rep_d.rd_bytes = cnt_val;
          3'd2: rep_d.wr_calls = cnt_val;
          3'd3: rep_d.wr_bytes = cnt_val;
          3'd4: rep_d.er_calls = cnt_val;
          default: rep_d.er_bytes = cnt_val;
        endcase
        ci_d = ci_q + 3'd1;
        sec_d = '0;
        st_d = (ci_q == 3'd5) ? StSecLat : StRepLat;
        if (ci_q == 3'd5) begin
          st_d = StRepSec;
          pass_d = 2'd0;
        end
      end
      StRepSec: begin
        // per sector: a wait state for the registered read, then one compare
        if (pass_q == 2'd0) begin
          pass_d = 2'd1;
        end else begin
          if (sec_val > rep_q.hot_count) begin
            rep_d.hot_count = sec_val;
            rep_d.hot_sector = 6'(sec_q);
          end
          if (sec_val != '0) rep_d.erased_sectors = rep_q.erased_sectors + 7'd1;
          sec_d = sec_q + SecCW'(1);
          pass_d = 2'd0;
          if (sec_q == SecCW'(Sectors - 1)) st_d = StDone;
        end
      end
      StDone: begin
        done_o = (func_q == fawm_pkg::FuncReport);
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; first_q <= '0; func_q <= '0; pass_q <= '0;
      set_q <= '0; ci_q <= '0; sec_q <= '0;
      epoch_wrap_q <= 1'b0;
      for (int i = 0; i < Sets; i++) epoch_q[i] <= '0;
    end else begin
      st_q <= st_d; first_q <= first_d; func_q <= func_d; pass_q <= pass_d;
      set_q <= set_d; ci_q <= ci_d; sec_q <= sec_d;
      epoch_wrap_q <= epoch_wrap_d;
      epoch_q <= epoch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d; last_q <= last_d; empty_q <= empty_d;
    phase_q <= phase_d; rep_q <= rep_d;
  end

  assign busy_o   = (st_q != StIdle);
  assign report_o = rep_q;

  a_done_only_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> func_q == fawm_pkg::FuncReport) else $error("result on non-report");
  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StDone |=> st_q == StIdle) else $error("done not followed by idle");

endmodule

[rtl/flash_access_wear_monitor.sv]
// flash_access_wear_monitor: top level with config registers and run flag.
// Depends on fawm_pkg and fawm_seq.
//
// Takes a command when start is high and busy low; busy then stays high for
// the whole command. A counted read or write adds to the calls and bytes
// counters of the run set, the campaign set and, when the phase is a bucket,
// that phase's set; a counted erase also adds one to each marked sector in
// each of those sets. A report reads the six counters of one set, then
// scans every sector of it. The counting uses one shared adder stepping a
// counter memory and a sector memory. A report result sits on the outputs
// for one cycle with valid_o high, in the last busy cycle, and cannot be
// stalled. After reset a tag sweep over every counter and sector word runs
// with busy high; config writes still land. Begin run clears sets by epoch;
// every 256th begin run also sweeps the run and phase entries, with busy
// high. SECTOR_BYTES must be a power of two.
module flash_access_wear_monitor #(
  parameter int unsigned SECTORS      = 64,
  parameter int unsigned SECTOR_BYTES = 4096,
  parameter int unsigned PHASES       = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic        op_ok_i,
  input  logic [31:0] target_base_i,
  input  logic [31:0] target_length_i,
  input  logic [31:0] byte_offset_i,
  input  logic [31:0] byte_count_i,
  input  logic [3:0]  phase_i,
  input  logic [3:0]  report_set_i,
  output logic        valid_o,
  output logic [31:0] rd_calls_o,
  output logic [31:0] rd_bytes_o,
  output logic [31:0] wr_calls_o,
  output logic [31:0] wr_bytes_o,
  output logic [31:0] er_calls_o,
  output logic [31:0] er_bytes_o,
  output logic [5:0]  hot_sector_o,
  output logic [31:0] hot_count_o,
  output logic [6:0]  erased_sectors_o
);

  logic        pvalid_q;
  logic [31:0] pbase_q, plen_q;
  logic        run_q;
  logic        go, hit;
  fawm_pkg::report_t rep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0; pbase_q <= '0; plen_q <= '0; run_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fawm_pkg::CfgValid:  pvalid_q <= cfg_wdata_i[0];
          fawm_pkg::CfgBase:   pbase_q  <= cfg_wdata_i;
          fawm_pkg::CfgLength: plen_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (go && func_i == fawm_pkg::FuncBegin) run_q <= 1'b1;
      if (go && func_i == fawm_pkg::FuncEnd)   run_q <= 1'b0;
    end
  end

  assign go  = start && !busy;
  assign hit = op_ok_i && run_q && pvalid_q &&
               target_base_i == pbase_q && target_length_i == plen_q;

  fawm_seq #(.Sectors(SECTORS), .SectorBytes(SECTOR_BYTES), .Phases(PHASES)) u_seq (
    .clk_i, .rst_ni, .go_i(go), .func_i, .hit_i(hit), .byte_offset_i,
    .byte_count_i, .phase_i, .report_set_i, .busy_o(busy), .done_o(valid_o),
    .report_o(rep)
  );

  assign rd_calls_o       = rep.rd_calls;
  assign rd_bytes_o       = rep.rd_bytes;
  assign wr_calls_o       = rep.wr_calls;
  assign wr_bytes_o       = rep.wr_bytes;
  assign er_calls_o       = rep.er_calls;
  assign er_bytes_o       = rep.er_bytes;
  assign hot_sector_o     = rep.hot_sector;
  assign hot_count_o      = rep.hot_count;
  assign erased_sectors_o = rep.erased_sectors;

endmodule
